@@ src/dq_pkg.sv @@
package dq_pkg;

  // Ring store geometry
  localparam int DEPTH = 1024;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int QAW        = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCW        = $clog2(CMDQ_DEPTH + 1);

  // Mode codes on the input word
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_PEEK_FRONT = 3'd4;
  localparam logic [2:0] MODE_PEEK_BACK  = 3'd5;
  localparam logic [2:0] MODE_SIZE       = 3'd6;
  localparam logic [2:0] MODE_EMPTY      = 3'd7;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_READ,
    KIND_SIZE,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        at_front;
    logic        remove;
    logic [31:0] value;
  } cmd_t;

  // (a + b) mod DEPTH for a < DEPTH, b <= DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

@@ src/dq_front.sv @@
module dq_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_push_value,
  input  logic               q_full,
  output logic               q_wr,
  output dq_pkg::cmd_t       q_wr_cmd
);

  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

  always_comb begin
    q_wr_cmd.value    = in_push_value;
    q_wr_cmd.kind     = dq_pkg::KIND_READ;
    q_wr_cmd.at_front = 1'b0;
    q_wr_cmd.remove   = 1'b0;
    unique case (in_mode)
      dq_pkg::MODE_PUSH_FRONT: begin
        q_wr_cmd.kind     = dq_pkg::KIND_PUSH;
        q_wr_cmd.at_front = 1'b1;
      end
      dq_pkg::MODE_PUSH_BACK: begin
        q_wr_cmd.kind = dq_pkg::KIND_PUSH;
      end
      dq_pkg::MODE_POP_FRONT: begin
        q_wr_cmd.at_front = 1'b1;
        q_wr_cmd.remove   = 1'b1;
      end
      dq_pkg::MODE_POP_BACK: begin
        q_wr_cmd.remove = 1'b1;
      end
      dq_pkg::MODE_PEEK_FRONT: begin
        q_wr_cmd.at_front = 1'b1;
      end
      dq_pkg::MODE_PEEK_BACK: begin
        q_wr_cmd.kind = dq_pkg::KIND_READ;
      end
      dq_pkg::MODE_SIZE: begin
        q_wr_cmd.kind = dq_pkg::KIND_SIZE;
      end
      dq_pkg::MODE_EMPTY: begin
        q_wr_cmd.kind = dq_pkg::KIND_EMPTY;
      end
      default: begin
        q_wr_cmd.kind = dq_pkg::KIND_READ;
      end
    endcase
  end

endmodule

@@ src/dq_cmd_fifo.sv @@
module dq_cmd_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  dq_pkg::cmd_t wr_cmd,
  output logic         full,
  output logic         rd_valid,
  output dq_pkg::cmd_t rd_cmd,
  input  logic         pop
);

  dq_pkg::cmd_t               slots_r [dq_pkg::CMDQ_DEPTH];
  logic [dq_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [dq_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [dq_pkg::QCW-1:0]     cnt_r, cnt_nxt;

  function automatic logic [dq_pkg::QAW-1:0] bump(input logic [dq_pkg::QAW-1:0] p);
    return (p == dq_pkg::QAW'(dq_pkg::CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (cnt_r == dq_pkg::QCW'(dq_pkg::CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!wr && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots_r[wr_ptr_r] <= wr_cmd;
  end

endmodule

@@ src/dq_back.sv @@
module dq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  dq_pkg::cmd_t       q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status
);

  logic [31:0]            entry_mem [dq_pkg::DEPTH];

  logic [dq_pkg::AW-1:0]  head_r, head_nxt;
  logic [dq_pkg::CW-1:0]  count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            res_val_r, res_val;
  dq_pkg::status_t        res_st_r, res_st;
  logic                   res_mem_r, res_mem;
  logic [31:0]            mem_q_r;
  logic                   has_res;

  logic                   issue, is_full, is_empty;
  logic                   we, re;
  logic [dq_pkg::AW-1:0]  waddr, raddr;
  logic [dq_pkg::AW-1:0]  head_dec, head_inc, tail_pos, back_pos;

  assign issue    = q_valid && (!out_valid_r || !out_stall);
  assign q_pop    = issue;
  assign is_full  = (count_r == dq_pkg::CW'(dq_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  assign head_dec = (head_r == '0) ? dq_pkg::AW'(dq_pkg::DEPTH - 1) : head_r - 1'b1;
  assign head_inc = dq_pkg::ring_add(head_r, dq_pkg::CW'(1));
  assign tail_pos = dq_pkg::ring_add(head_r, count_r);
  assign back_pos = dq_pkg::ring_add(head_r, count_r - dq_pkg::CW'(1));

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = tail_pos;
    raddr     = head_r;
    has_res   = 1'b0;
    res_val   = '0;
    res_st    = dq_pkg::ST_OK;
    res_mem   = 1'b0;
    if (issue) begin
      unique case (q_cmd.kind)
        dq_pkg::KIND_PUSH: begin
          if (is_full) begin
            has_res = 1'b1;
            res_st  = dq_pkg::ST_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + dq_pkg::CW'(1);
            if (q_cmd.at_front) begin
              head_nxt = head_dec;
              waddr    = head_dec;
            end
          end
        end
        dq_pkg::KIND_READ: begin
          has_res = 1'b1;
          if (is_empty) begin
            res_val = '1;
            res_st  = dq_pkg::ST_EMPTY;
          end else begin
            re      = 1'b1;
            res_mem = 1'b1;
            raddr   = q_cmd.at_front ? head_r : back_pos;
            if (q_cmd.remove) begin
              count_nxt = count_r - dq_pkg::CW'(1);
              if (q_cmd.at_front) head_nxt = head_inc;
            end
          end
        end
        dq_pkg::KIND_SIZE: begin
          has_res = 1'b1;
          res_val = 32'(count_r);
        end
        dq_pkg::KIND_EMPTY: begin
          has_res = 1'b1;
          res_val = {31'b0, is_empty};
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (issue) out_valid_nxt = has_res;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      res_val_r <= res_val;
      res_st_r  <= res_st;
      res_mem_r <= res_mem;
    end
  end

  // single-port style store: at most one access per command
  always_ff @(posedge clk) begin
    if (we) entry_mem[waddr] <= q_cmd.value;
    if (re) mem_q_r <= entry_mem[raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(res_mem_r ? mem_q_r : res_val_r);
  assign out_status       = res_st_r;

endmodule

@@ src/double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit words in a ring store.
// Input channel: in_valid / in_stall with in_mode and in_push_value. A word
//   is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_result_value, out_status.
//   Pushes that fit give no output word; a push to a full queue gives one
//   word with status full and value 0. Every other mode gives one word.
// Structure: the front decodes the mode into a command and writes it to a
//   two-entry command queue; the back runs one command per cycle, unless a
//   held result stalls it, against the head pointer, the count and the ring
//   store, then the output register.
// Path: a taken word is written into the command queue; the back executes
//   it from there and registers its result in the output register.
// Throughput: one command per cycle unless out_stall holds a result; a
//   command makes at most one access (push write, pop/peek registered read).
// Stall: while out_stall holds a result, the back halts; the command queue
//   fills and in_stall rises within two more words. Results are never lost.
// Reset (synchronous, rst_n low): head and count go to zero and both
//   queues empty. Store contents stay undefined; no clearing pass is run.
module double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status
);

  logic         q_full;
  logic         q_wr;
  dq_pkg::cmd_t q_wr_cmd;
  logic         q_valid;
  dq_pkg::cmd_t q_cmd;
  logic         q_pop;

  // front: decode mode into a command word
  dq_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_push_value (in_push_value),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_wr_cmd      (q_wr_cmd)
  );

  // decoupling queue
  dq_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_cmd   (q_wr_cmd),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .pop      (q_pop)
  );

  // back: pointers, ring store, result register
  dq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  // back never takes a command the queue does not hold
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // empty status always carries -1
  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == dq_pkg::ST_EMPTY)) |-> (out_result_value == -32'sd1))
    else $error("empty status without -1");

  // dropped push always carries 0
  a_full_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == dq_pkg::ST_FULL)) |-> (out_result_value == 32'sd0))
    else $error("full status with non-zero value");

  // a taken command is visible to the back the next cycle when no result is on the output
  a_cmd_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr && !out_valid) |=> q_valid)
    else $error("accepted command not visible to back");

endmodule

@@ test/tb.sv @@
module tb;

  // Sets the watchdog limit: far beyond the slowest legal run
  // (~1100 words, each with long gaps and long result stalls).
  localparam int CYCLE_LIMIT = 1000000;

  // One result word as the block should present it
  typedef struct {
    logic signed [31:0] value;
    dq_pkg::status_t    status;
  } dq_result_t;

  // Mirror of the deque. It keeps its own ring, head and fill, and lines up
  // the result words that each accepted command should produce.
  class deque_mirror;
    logic [31:0] ring [dq_pkg::DEPTH];
    int unsigned head_pos;
    int unsigned fill;
    dq_result_t  due_results [$];
    int          mismatches;

    function new();
      head_pos   = 0;
      fill       = 0;
      mismatches = 0;
    endfunction

    function void take_command(logic [2:0] mode, logic [31:0] value);
      dq_result_t  res;
      int unsigned pos;
      res.value  = '0;
      res.status = dq_pkg::ST_OK;
      case (mode) inside
        dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
          if (fill >= dq_pkg::DEPTH) begin
            // full: word dropped, a single result with value 0
            res.status = dq_pkg::ST_FULL;
            due_results.insert(due_results.size(), res);
            return;
          end
          if (mode == dq_pkg::MODE_PUSH_FRONT) begin
            head_pos       = (head_pos + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
            ring[head_pos] = value;
          end else begin
            ring[(head_pos + fill) % dq_pkg::DEPTH] = value;
          end
          fill++;
          return;
        end
        dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK,
        dq_pkg::MODE_PEEK_FRONT, dq_pkg::MODE_PEEK_BACK: begin
          if (fill == 0) begin
            res.value  = -1;
            res.status = dq_pkg::ST_EMPTY;
          end else begin
            if (mode == dq_pkg::MODE_POP_FRONT || mode == dq_pkg::MODE_PEEK_FRONT)
              pos = head_pos;
            else
              pos = (head_pos + fill - 1) % dq_pkg::DEPTH;
            res.value = ring[pos];
            if (mode == dq_pkg::MODE_POP_FRONT) begin
              head_pos = (head_pos + 1) % dq_pkg::DEPTH;
              fill--;
            end else if (mode == dq_pkg::MODE_POP_BACK) begin
              fill--;
            end
          end
        end
        dq_pkg::MODE_SIZE:  res.value = fill;
        dq_pkg::MODE_EMPTY: res.value = (fill == 0) ? 1 : 0;
        default:            res.value = '0;
      endcase
      due_results.insert(due_results.size(), res);
    endfunction

    function void match_result(logic signed [31:0] value, logic [1:0] status);
      dq_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: expected no result word, actual value %0d status %0d",
                 $time, value, status);
        mismatches++;
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      if (value !== want.value) begin
        $display("%0t: result_value expected %0d actual %0d",
                 $time, want.value, value);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d",
                 $time, want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_mode;
  logic signed [31:0] in_push_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_result_value;
  logic [1:0]         out_status;

  deque_mirror mirror;
  int          cycles = 0;
  int          burst_left;

  double_ended_queue u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("double_ended_queue test failed");
      $finish;
    end
  end

  // Result side: a word moves when out_valid is high and out_stall low at the
  // edge. Values seen here are the pre-edge ones, so no race with the block.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      mirror.match_result(out_result_value, out_status);
  end

  // Idle length: eight draws in ten are short, the rest long
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Gap ahead of the next input word; bursts give runs with no gaps at all
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(30, 100);
      return 0;
    end
    if ($urandom_range(0, 1) == 0)
      return 0;
    return idle_len();
  endfunction

  // Receiver stalls: short and long stalls, with quiet stretches between
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 150)) @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word
  // has been taken. in_valid stays high straight into the next word when
  // there is no gap, so it never gets two assignments in one step.
  task automatic send_word(input logic [2:0] mode, input logic [31:0] value);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode       <= mode;
    in_push_value <= value;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    mirror.take_command(mode, value);
    @(negedge clk);
  endtask

  // Push and pop weights in percent; the rest are peeks and queries
  function automatic logic [2:0] pick_mode(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      return 3'($urandom_range(int'(dq_pkg::MODE_PUSH_FRONT), int'(dq_pkg::MODE_PUSH_BACK)));
    if (r < push_pct + pop_pct)
      return 3'($urandom_range(int'(dq_pkg::MODE_POP_FRONT), int'(dq_pkg::MODE_POP_BACK)));
    return 3'($urandom_range(int'(dq_pkg::MODE_PEEK_FRONT), int'(dq_pkg::MODE_EMPTY)));
  endfunction

  // Mostly random words, some corner values
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    mirror        = new();
    burst_left    = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = dq_pkg::MODE_SIZE;
    in_push_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: queries and reads on an empty deque, then pushes at both ends (the
    // first front push wraps the head below zero), reads from both ends, draining
    // to empty, a read once empty, then a push and pop at each end and a query.
    send_word(dq_pkg::MODE_EMPTY,      pick_word());
    send_word(dq_pkg::MODE_SIZE,       pick_word());
    send_word(dq_pkg::MODE_POP_FRONT,  pick_word());
    send_word(dq_pkg::MODE_POP_BACK,   pick_word());
    send_word(dq_pkg::MODE_PEEK_FRONT, pick_word());
    send_word(dq_pkg::MODE_PEEK_BACK,  pick_word());
    send_word(dq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(dq_pkg::MODE_PUSH_BACK,  32'h8000_0000);
    send_word(dq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(dq_pkg::MODE_PUSH_BACK,  32'h0000_0000);
    send_word(dq_pkg::MODE_PEEK_FRONT, pick_word());
    send_word(dq_pkg::MODE_PEEK_BACK,  pick_word());
    send_word(dq_pkg::MODE_SIZE,       pick_word());
    send_word(dq_pkg::MODE_EMPTY,      pick_word());
    send_word(dq_pkg::MODE_POP_BACK,   pick_word());
    send_word(dq_pkg::MODE_POP_FRONT,  pick_word());
    send_word(dq_pkg::MODE_POP_FRONT,  pick_word());
    send_word(dq_pkg::MODE_POP_BACK,   pick_word());
    send_word(dq_pkg::MODE_POP_FRONT,  pick_word());
    send_word(dq_pkg::MODE_PUSH_BACK,  32'h5555_5555);
    send_word(dq_pkg::MODE_PUSH_FRONT, 32'hAAAA_AAAA);
    send_word(dq_pkg::MODE_POP_FRONT,  pick_word());
    send_word(dq_pkg::MODE_POP_BACK,   pick_word());
    send_word(dq_pkg::MODE_EMPTY,      pick_word());

    // Random: push-heavy until the ring is full, so both pointers wrap
    while (mirror.fill < dq_pkg::DEPTH)
      send_word(pick_mode(98, 0), pick_word());
    // hover at full: dropped pushes mixed with pops that make room again
    repeat (10)
      send_word(pick_mode(60, 10), pick_word());
    // balanced traffic from high fill
    repeat (10)
      send_word(pick_mode(35, 35), pick_word());

    in_valid <= 1'b0;

    // Drain: wait for every due result, then keep watching for stray words
    while (mirror.due_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mirror.mismatches == 0)
      $display("double_ended_queue test passed");
    else
      $display("double_ended_queue test failed");
    $finish;
  end

endmodule
